// ===== hw/rtl/cpfm_pkg.sv =====
// cpfm_pkg: shared widths, reset values and defaults for the capture period
// frequency meter; no dependencies, compiled first
package cpfm_pkg;

  localparam int TIMER_BITS_DEF = 16;

  localparam int OPCODE_W   = 1;
  localparam int STAMP_IN_W = 16;
  localparam int CLOCK_HZ_W = 27;
  localparam int PERIOD_W   = 32;
  localparam int FREQ_W     = 34;
  localparam int OVF_W      = 16;

  localparam logic [CLOCK_HZ_W-1:0] CLOCK_HZ_RESET = CLOCK_HZ_W'(10000000);
  localparam logic [OVF_W-1:0]      OVF_MAX        = '1;

  // event kinds
  localparam logic [OPCODE_W-1:0] OP_OVERFLOW = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_CAPTURE  = 1'b1;

endpackage

// ===== hw/rtl/cpfm_evt_if.sv =====
// cpfm_evt_if: event channel (overflow tick or capture) with valid/ready
// depends on cpfm_pkg
interface cpfm_evt_if;
  logic                                valid;
  logic                                ready;
  logic [cpfm_pkg::OPCODE_W-1:0]       opcode;
  logic [cpfm_pkg::STAMP_IN_W-1:0]     captured_time;

  modport source (output valid, output opcode, output captured_time, input ready);
  modport sink   (input valid, input opcode, input captured_time, output ready);
endinterface

// ===== hw/rtl/cpfm_res_if.sv =====
// cpfm_res_if: measurement result channel with valid/ready
// depends on cpfm_pkg
interface cpfm_res_if;
  logic                              valid;
  logic                              ready;
  logic [cpfm_pkg::PERIOD_W-1:0]     period_ticks;
  logic [cpfm_pkg::FREQ_W-1:0]       freq_centihz;
  logic                              zero_period;
  logic                              overflow_saturated;

  modport source (output valid, output period_ticks, output freq_centihz,
                  output zero_period, output overflow_saturated, input ready);
  modport sink   (input valid, input period_ticks, input freq_centihz,
                  input zero_period, input overflow_saturated, output ready);
endinterface

// ===== hw/rtl/cpfm_cfg_if.sv =====
// cpfm_cfg_if: configuration write channel for the clock_hz register
// depends on cpfm_pkg
interface cpfm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [cpfm_pkg::CLOCK_HZ_W-1:0]     clock_hz;

  modport source (output valid, output clock_hz, input ready);
  modport sink   (input valid, input clock_hz, output ready);
endinterface

// ===== hw/rtl/capture_period_frequency_meter_unit.sv =====
// capture_period_frequency_meter_unit: overflow ticks and start captures need no division;
// an end capture's result takes 34 restoring divider steps, one quotient bit per cycle,
// then the output load; a zero period skips the steps and goes straight to the output load
// events are held off from an end capture until its result is loaded, longer while an earlier
// result waits; config always ready; rst (sync, active high) clears state, clock_hz 10 MHz
module capture_period_frequency_meter_unit #(
  parameter int TIMER_BITS = cpfm_pkg::TIMER_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  cpfm_evt_if.sink   evt,
  cpfm_cfg_if.sink   cfg,
  cpfm_res_if.source res
);

  // captured stamp keeps at most the 16 bits the event carries
  localparam int STAMP_W   = (TIMER_BITS < cpfm_pkg::STAMP_IN_W) ? TIMER_BITS
                                                                 : cpfm_pkg::STAMP_IN_W;
  // wide enough for the shifted count and never narrower than the period
  localparam int OVF_EXT_W = (cpfm_pkg::OVF_W + TIMER_BITS > cpfm_pkg::PERIOD_W)
                           ? cpfm_pkg::OVF_W + TIMER_BITS : cpfm_pkg::PERIOD_W;
  localparam int DIV_STEPS = cpfm_pkg::FREQ_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;

  logic [1:0] state;

  // measurement state
  logic                              phase;
  logic [STAMP_W-1:0]                start_stamp;
  logic [cpfm_pkg::OVF_W-1:0]        ovf_count;
  logic                              sat_mark;
  logic [cpfm_pkg::CLOCK_HZ_W-1:0]   clock_hz;

  // divider registers
  logic [cpfm_pkg::PERIOD_W-1:0]     period;   // divisor, also reported
  logic [cpfm_pkg::FREQ_W-1:0]       dvd;      // dividend in, quotient out
  logic [cpfm_pkg::PERIOD_W-1:0]     rem;
  logic [CNT_W-1:0]                  step_cnt;
  logic                              zero_flag;
  logic                              sat_flag;

  logic evt_xfer;
  logic end_capture;
  logic ovf_tick;
  logic start_capture;
  logic div_done;

  logic [OVF_EXT_W-1:0]              ovf_wide;
  logic [cpfm_pkg::PERIOD_W-1:0]     period_next;
  logic [cpfm_pkg::FREQ_W-1:0]       scaled_hz;
  logic [cpfm_pkg::PERIOD_W:0]       trial;
  logic [cpfm_pkg::PERIOD_W:0]       trial_diff;
  logic                              q_bit;
  logic [cpfm_pkg::OVF_W-1:0]        ovf_inc;

  // events only while the divider is idle
  assign evt.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  assign evt_xfer      = evt.valid && evt.ready;
  assign ovf_tick      = evt_xfer && (evt.opcode == cpfm_pkg::OP_OVERFLOW);
  assign start_capture = evt_xfer && (evt.opcode == cpfm_pkg::OP_CAPTURE) && !phase;
  assign end_capture   = evt_xfer && (evt.opcode == cpfm_pkg::OP_CAPTURE) && phase;

  // overflows weighted by the timer span, wrapped to 32 bits
  assign ovf_wide    = OVF_EXT_W'(ovf_count) << TIMER_BITS;
  assign period_next = ovf_wide[cpfm_pkg::PERIOD_W-1:0]
                     + cpfm_pkg::PERIOD_W'(evt.captured_time[STAMP_W-1:0])
                     - cpfm_pkg::PERIOD_W'(start_stamp);

  // clock_hz * 100 as 64 + 32 + 4
  assign scaled_hz = (cpfm_pkg::FREQ_W'(clock_hz) << 6)
                   + (cpfm_pkg::FREQ_W'(clock_hz) << 5)
                   + (cpfm_pkg::FREQ_W'(clock_hz) << 2);

  // one restoring division step: bring down the next dividend bit
  assign trial      = {rem, dvd[cpfm_pkg::FREQ_W-1]};
  assign trial_diff = trial - {1'b0, period};
  assign q_bit      = !trial_diff[cpfm_pkg::PERIOD_W];

  assign ovf_inc = (ovf_count == cpfm_pkg::OVF_MAX) ? ovf_count : ovf_count + 1'b1;

  // result goes out once all bits are in and the output register is free
  assign div_done = (state == ST_DIV) && (step_cnt == '0) && (!res.valid || res.ready);

  // control and measurement state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= 1'b0;
      ovf_count <= '0;
      sat_mark  <= 1'b0;
      clock_hz  <= cpfm_pkg::CLOCK_HZ_RESET;
      res.valid <= 1'b0;
      step_cnt  <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        clock_hz <= cfg.clock_hz;
      end
      // a new result loading in the same cycle keeps valid high
      if (res.valid && res.ready && !div_done) begin
        res.valid <= 1'b0;
      end
      if (ovf_tick) begin
        ovf_count <= ovf_inc;
        if (ovf_inc == cpfm_pkg::OVF_MAX) begin
          sat_mark <= 1'b1;
        end
      end
      if (start_capture) begin
        phase     <= 1'b1;
        ovf_count <= '0;
        sat_mark  <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (end_capture) begin
            phase     <= 1'b0;
            ovf_count <= '0;
            sat_mark  <= 1'b0;
            state     <= ST_DIV;
            // a zero period skips the division entirely
            step_cnt  <= (period_next == '0) ? '0 : CNT_W'(DIV_STEPS);
          end
        end
        ST_DIV: begin
          if (step_cnt != '0) begin
            step_cnt <= step_cnt - 1'b1;
          end else if (div_done) begin
            res.valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start_capture) begin
      start_stamp <= evt.captured_time[STAMP_W-1:0];
    end
    if (end_capture) begin
      period    <= period_next;
      zero_flag <= (period_next == '0);
      sat_flag  <= sat_mark;
      rem       <= '0;
      dvd       <= (period_next == '0) ? '0 : scaled_hz;
    end else if ((state == ST_DIV) && (step_cnt != '0)) begin
      if (q_bit) begin
        rem <= trial_diff[cpfm_pkg::PERIOD_W-1:0];
      end else begin
        rem <= trial[cpfm_pkg::PERIOD_W-1:0];
      end
      dvd <= {dvd[cpfm_pkg::FREQ_W-2:0], q_bit};
    end
    if (div_done) begin
      res.period_ticks       <= period;
      res.freq_centihz       <= dvd;
      res.zero_period        <= zero_flag;
      res.overflow_saturated <= sat_flag;
    end
  end

`ifndef SYNTHESIS
  // an end capture always moves the unit into the divide state
  a_end_starts_div: assert property (@(posedge clk) disable iff (rst)
    end_capture |=> (state == ST_DIV))
    else $error("end capture did not start the divider");

  // a saturated overflow count always carries its mark
  a_sat_mark: assert property (@(posedge clk) disable iff (rst)
    (ovf_count == cpfm_pkg::OVF_MAX) |-> sat_mark)
    else $error("overflow count saturated without mark");

  // zero period reports zero frequency
  a_zero_freq: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.zero_period) |-> (res.freq_centihz == '0))
    else $error("zero period with nonzero frequency");

  // step counter never exceeds the quotient width
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step_cnt <= CNT_W'(DIV_STEPS))
    else $error("divider step counter out of range");

  // no event is taken while a division runs
  a_no_evt_in_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> !evt_xfer)
    else $error("event accepted during division");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for capture_period_frequency_meter_unit
// uses cpfm_pkg and the cpfm_evt_if, cpfm_cfg_if and cpfm_res_if channels
module testbench;

  // cycles the unit may still need after the last expected result, used before
  // register writes and at the end
  localparam int SETTLE_CYCLES = 40;
  // receiver hold-off that backs the unit up into its event input
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 190;
  // ticks inside the one long directed measurement
  localparam int LONG_TICKS    = 100;

  typedef struct packed {
    logic [cpfm_pkg::OPCODE_W-1:0]   op;
    logic [cpfm_pkg::STAMP_IN_W-1:0] stamp;
  } meter_event_t;

  typedef struct packed {
    logic [cpfm_pkg::PERIOD_W-1:0] period;
    logic [cpfm_pkg::FREQ_W-1:0]   freq;
    logic                          zero;
    logic                          sat;
  } meter_result_t;

  logic clk;
  logic rst;

  cpfm_evt_if evt_ch ();
  cpfm_cfg_if cfg_ch ();
  cpfm_res_if res_ch ();

  capture_period_frequency_meter_unit dut (
    .clk (clk),
    .rst (rst),
    .evt (evt_ch),
    .cfg (cfg_ch),
    .res (res_ch)
  );

  // events waiting to be offered, and measurements the unit still owes us
  meter_event_t  pending_events [$];
  meter_result_t expected_meas  [$];
  int unsigned   mismatch_count = 0;

  // flow control knobs, changed only from the sequencer at falling edges
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        recv_hold      = 1'b0;

  // shadow of the meter state, starts at its reset values
  logic [cpfm_pkg::CLOCK_HZ_W-1:0] model_clock_hz  = cpfm_pkg::CLOCK_HZ_RESET;
  logic                            model_in_period = 1'b0;
  logic [cpfm_pkg::STAMP_IN_W-1:0] model_start     = '0;
  logic [cpfm_pkg::OVF_W-1:0]      model_ovf_count = '0;
  logic                            model_sat       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // timeout
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // advance the shadow state by one accepted event and queue any measurement
  function automatic void predict_measurement(input logic [cpfm_pkg::OPCODE_W-1:0] op,
                                              input logic [cpfm_pkg::STAMP_IN_W-1:0] stamp);
    meter_result_t r;
    logic [cpfm_pkg::PERIOD_W-1:0] period;
    if (op == cpfm_pkg::OP_OVERFLOW) begin
      // count in either phase, hold at the top and remember that we got there
      if (model_ovf_count != cpfm_pkg::OVF_MAX) model_ovf_count = model_ovf_count + 1'b1;
      if (model_ovf_count == cpfm_pkg::OVF_MAX) model_sat = 1'b1;
    end else if (!model_in_period) begin
      // start capture: latch stamp and clear anything counted before it
      model_start     = stamp;
      model_ovf_count = '0;
      model_sat       = 1'b0;
      model_in_period = 1'b1;
    end else begin
      // end capture: period wraps modulo 2^32
      period = (cpfm_pkg::PERIOD_W'(model_ovf_count) << cpfm_pkg::STAMP_IN_W)
               + cpfm_pkg::PERIOD_W'(stamp) - cpfm_pkg::PERIOD_W'(model_start);
      r.period = period;
      r.zero   = (period == '0);
      r.freq   = r.zero ? '0
                        : cpfm_pkg::FREQ_W'((64'(model_clock_hz) * 64'd100) / 64'(period));
      r.sat    = model_sat;
      expected_meas.push_back(r);
      model_ovf_count = '0;
      model_sat       = 1'b0;
      model_in_period = 1'b0;
    end
  endfunction

  // event driver: holds an offered event until transfer, may idle in between
  always @(posedge clk) begin : drive_events
    meter_event_t nxt;
    if (rst) begin
      evt_ch.valid <= 1'b0;
    end else begin
      if (evt_ch.valid && evt_ch.ready) begin
        predict_measurement(evt_ch.opcode, evt_ch.captured_time);
      end
      if (!evt_ch.valid || evt_ch.ready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_events.pop_front();
          evt_ch.valid         <= 1'b1;
          evt_ch.opcode        <= nxt.op;
          evt_ch.captured_time <= nxt.stamp;
        end else begin
          // junk payload while idle
          evt_ch.valid         <= 1'b0;
          evt_ch.opcode        <= cpfm_pkg::OPCODE_W'($urandom);
          evt_ch.captured_time <= cpfm_pkg::STAMP_IN_W'($urandom);
        end
      end
    end
  end

  // result monitor: compares each transfer with the oldest expected measurement
  always @(posedge clk) begin : check_results
    meter_result_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_meas.size() == 0) begin
          $display("%0t: unexpected result period_ticks %0d freq_centihz %0d",
                   $time, res_ch.period_ticks, res_ch.freq_centihz);
          mismatch_count++;
        end else begin
          want = expected_meas.pop_front();
          if (res_ch.period_ticks !== want.period) begin
            $display("%0t: period_ticks expected %0d actual %0d",
                     $time, want.period, res_ch.period_ticks);
            mismatch_count++;
          end
          if (res_ch.freq_centihz !== want.freq) begin
            $display("%0t: freq_centihz expected %0d actual %0d",
                     $time, want.freq, res_ch.freq_centihz);
            mismatch_count++;
          end
          if (res_ch.zero_period !== want.zero) begin
            $display("%0t: zero_period expected %0b actual %0b",
                     $time, want.zero, res_ch.zero_period);
            mismatch_count++;
          end
          if (res_ch.overflow_saturated !== want.sat) begin
            $display("%0t: overflow_saturated expected %0b actual %0b",
                     $time, want.sat, res_ch.overflow_saturated);
            mismatch_count++;
          end
        end
      end
      res_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_event(input logic [cpfm_pkg::OPCODE_W-1:0] op,
                             input logic [cpfm_pkg::STAMP_IN_W-1:0] stamp);
    meter_event_t e;
    e.op    = op;
    e.stamp = stamp;
    pending_events.push_back(e);
  endtask

  // timer stamp with extra weight on the ends of the range
  function automatic logic [cpfm_pkg::STAMP_IN_W-1:0] pick_stamp();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return cpfm_pkg::STAMP_IN_W'($urandom);
  endfunction

  // mostly full start/ticks/end measurements, some stray events that knock the
  // capture phase out of step
  task automatic queue_random_traffic(input int unsigned n_items);
    int unsigned queued;
    int unsigned ticks;
    logic [cpfm_pkg::STAMP_IN_W-1:0] t0;
    queued = 0;
    while (queued < n_items) begin
      if ($urandom_range(99) < 85) begin
        t0    = pick_stamp();
        ticks = ($urandom_range(99) < 80) ? $urandom_range(3) : $urandom_range(60, 4);
        queue_event(cpfm_pkg::OP_CAPTURE, t0);
        repeat (ticks) queue_event(cpfm_pkg::OP_OVERFLOW, cpfm_pkg::STAMP_IN_W'($urandom));
        queue_event(cpfm_pkg::OP_CAPTURE, ($urandom_range(99) < 15) ? t0 : pick_stamp());
        queued += ticks + 2;
      end else begin
        queue_event(cpfm_pkg::OPCODE_W'($urandom_range(1)), pick_stamp());
        queued += 1;
      end
    end
  endtask

  // sender pause: wait until everything is sent and every result is back
  task automatic settle();
    while (pending_events.size() != 0 || evt_ch.valid || expected_meas.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // clock_hz write, only issued while the unit is idle
  task automatic write_clock_hz(input logic [cpfm_pkg::CLOCK_HZ_W-1:0] hz);
    @(posedge clk);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.clock_hz <= hz;
    do @(posedge clk); while (!cfg_ch.ready);
    model_clock_hz = hz;
    cfg_ch.valid    <= 1'b0;
    @(negedge clk);
  endtask

  // sequencer
  initial begin : run
    logic [cpfm_pkg::CLOCK_HZ_W-1:0] hz_plan [PHASES-1];
    // known values on every input from time zero
    rst                  = 1'b1;
    evt_ch.valid         = 1'b0;
    evt_ch.opcode        = cpfm_pkg::OP_OVERFLOW;
    evt_ch.captured_time = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.clock_hz      = cpfm_pkg::CLOCK_HZ_RESET;
    res_ch.ready         = 1'b0;
    // slowest, fastest-by-width and top-of-range clocks, some random, then back
    hz_plan[0] = cpfm_pkg::CLOCK_HZ_W'(1);
    hz_plan[1] = '1;
    hz_plan[2] = cpfm_pkg::CLOCK_HZ_W'(100_000_000);
    hz_plan[3] = cpfm_pkg::CLOCK_HZ_W'($urandom_range(100_000_000, 1));
    hz_plan[4] = cpfm_pkg::CLOCK_HZ_W'($urandom_range(1000, 2));
    hz_plan[5] = cpfm_pkg::CLOCK_HZ_W'($urandom_range(100_000_000, 1));
    hz_plan[6] = cpfm_pkg::CLOCK_HZ_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at the reset clock_hz
    // ticks before the start capture must not count toward the period
    queue_event(cpfm_pkg::OP_OVERFLOW, 16'h0000);
    queue_event(cpfm_pkg::OP_OVERFLOW, 16'hFFFF);
    queue_event(cpfm_pkg::OP_CAPTURE,  16'h0005);
    queue_event(cpfm_pkg::OP_CAPTURE,  16'h0005);   // zero period, no division
    // shortest nonzero period, largest frequency
    queue_event(cpfm_pkg::OP_CAPTURE,  16'h0000);
    queue_event(cpfm_pkg::OP_CAPTURE,  16'h0001);
    // end stamp below start with no ticks: period wraps around 2^32
    queue_event(cpfm_pkg::OP_CAPTURE,  16'hFFFF);
    queue_event(cpfm_pkg::OP_CAPTURE,  16'h0000);
    // end below start with ticks in between
    queue_event(cpfm_pkg::OP_CAPTURE,  16'h1234);
    queue_event(cpfm_pkg::OP_OVERFLOW, 16'hABCD);
    queue_event(cpfm_pkg::OP_OVERFLOW, 16'h5432);
    queue_event(cpfm_pkg::OP_CAPTURE,  16'h1233);
    // exactly one timer wrap
    queue_event(cpfm_pkg::OP_CAPTURE,  16'hFFFF);
    queue_event(cpfm_pkg::OP_OVERFLOW, 16'h0000);
    queue_event(cpfm_pkg::OP_CAPTURE,  16'hFFFF);
    // alternating bit patterns on the stamp
    queue_event(cpfm_pkg::OP_CAPTURE,  16'hAAAA);
    queue_event(cpfm_pkg::OP_OVERFLOW, 16'h5555);
    queue_event(cpfm_pkg::OP_CAPTURE,  16'h5555);
    settle();

    // long run of ticks inside one measurement; the next measurement is clean
    queue_event(cpfm_pkg::OP_CAPTURE, 16'h0000);
    repeat (LONG_TICKS) queue_event(cpfm_pkg::OP_OVERFLOW, cpfm_pkg::STAMP_IN_W'($urandom));
    queue_event(cpfm_pkg::OP_CAPTURE, 16'hFFFF);
    queue_event(cpfm_pkg::OP_CAPTURE, 16'h0000);
    queue_event(cpfm_pkg::OP_CAPTURE, 16'h0010);
    settle();

    // random phases, each with its own clock_hz and flow control mix
    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) write_clock_hz(hz_plan[p-1]);
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 68;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 68;
        end
        default: begin
          send_idle_pct  = 12;
          recv_stall_pct = 12;
        end
      endcase
      queue_random_traffic(PHASE_ITEMS);
      if (p == 0) begin
        // receiver holds off while events keep coming, unit must back up
        recv_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        recv_hold = 1'b0;
      end
      settle();
    end

    if (mismatch_count == 0 && expected_meas.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/cpfm_pkg.sv
hw/rtl/cpfm_evt_if.sv
hw/rtl/cpfm_res_if.sv
hw/rtl/cpfm_cfg_if.sv
hw/rtl/capture_period_frequency_meter_unit.sv
verif/testbench.sv
